// ===== src/mcid_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mcid_pkg;

  localparam int CHANNELS       = 15;
  localparam int COUNT_BITS_DEF = 10;
  localparam int THR_W          = 10;
  localparam int SETTLE_W       = 11;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 11;
  localparam int GROUPS         = 5;

  // fixed channel roles
  localparam int CH_CMD_A    = 4;
  localparam int CH_CMD_B    = 5;
  localparam int CH_DISC1_LO = 8;
  localparam int CH_DISC1_HI = 9;
  localparam int CH_DISC2_LO = 12;
  localparam int CH_DISC2_HI = 13;

  // reset values of the config registers
  localparam logic [THR_W-1:0]    SENSOR_THR_RST   = THR_W'(50);
  localparam logic [THR_W-1:0]    COMMAND_THR_RST  = THR_W'(500);
  localparam logic [THR_W-1:0]    ENCODER_THR_RST  = THR_W'(2);
  localparam logic [THR_W-1:0]    DISC_THR_RST     = THR_W'(20);
  localparam logic [THR_W-1:0]    DETECTOR_THR_RST = THR_W'(5);
  localparam logic [SETTLE_W-1:0] SETTLE_RST       = SETTLE_W'(1000);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SENSOR_THR   = 3'd0,
    REG_COMMAND_THR  = 3'd1,
    REG_ENCODER_THR  = 3'd2,
    REG_DISC_THR     = 3'd3,
    REG_DETECTOR_THR = 3'd4,
    REG_SETTLE       = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    GRP_SENSOR   = 3'd0,
    GRP_COMMAND  = 3'd1,
    GRP_ENCODER  = 3'd2,
    GRP_DISC     = 3'd3,
    GRP_DETECTOR = 3'd4
  } group_t;

  typedef enum logic [1:0] {
    CMD_NONE      = 2'd0,
    CMD_OPEN_IN   = 2'd1,
    CMD_OPEN_OUT  = 2'd2,
    CMD_PICTOGRAM = 2'd3
  } cmd_t;

  function automatic group_t group_of(input int ch);
    case (ch)
      0, 1, 2, 3:     group_of = GRP_SENSOR;
      4, 5:           group_of = GRP_COMMAND;
      6, 7, 10, 11:   group_of = GRP_ENCODER;
      8, 9, 12, 13:   group_of = GRP_DISC;
      default:        group_of = GRP_DETECTOR;
    endcase
  endfunction

  function automatic cmd_t decode_command(input logic a, input logic b);
    case ({a, b})
      2'b11:   decode_command = CMD_NONE;
      2'b01:   decode_command = CMD_OPEN_IN;
      2'b10:   decode_command = CMD_OPEN_OUT;
      default: decode_command = CMD_PICTOGRAM;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== src/multi_channel_integrating_debouncer.sv =====
`timescale 1ns / 1ps
// multi-channel integrating debouncer
// input channel: raw_pins with raw_valid / raw_stall, one item per sampling tick,
//   bit i of raw_pins is the raw level of channel i
// result channel: stable_pins, command_code, disc codes and change pulses with
//   result_valid / result_stall, exactly one result item per input item
// config port: cfg_write, cfg_index, cfg_data; indexes 0..4 are the group
//   thresholds, 5 the command settle count, others are ignored; write only
//   while no item is in flight
// data path: an accepted item is held in the input register and moves to the
//   result register once that register is empty or being read, so
//   result_valid follows acceptance whenever the receiver is not stalling
// throughput: one item per cycle unless the receiver stalls; each item's update
//   is one pass of compare and count step per channel plus the settle counter compare
// a stalled receiver holds the result register; one more item is taken into
//   the input register, after that raw_stall stays high until the result
//   register drains
// reset (rst, synchronous): counts, levels, command settling and disc codes
//   clear, thresholds and settle count go to their defaults, both channels
//   empty
`default_nettype none
module multi_channel_integrating_debouncer
  import mcid_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // config port
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  wire logic                   raw_valid,
  output logic                        raw_stall,
  input  wire logic [CHANNELS-1:0]    raw_pins,
  // result channel
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [CHANNELS-1:0]         stable_pins,
  output logic [1:0]                  command_code,
  output logic [1:0]                  disc_code_first,
  output logic [1:0]                  disc_code_second,
  output logic                        disc_changed_first,
  output logic                        disc_changed_second
);

  // compare width covers both the counter and the threshold
  localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // config registers
  logic [THR_W-1:0]    thr_reg [GROUPS];
  logic [SETTLE_W-1:0] settle_ticks;

  // input register
  logic                s1_valid;
  logic [CHANNELS-1:0] s1_raw;

  // debounce state
  logic [COUNT_BITS-1:0] counts [CHANNELS];
  logic [COUNT_BITS-1:0] counts_next [CHANNELS];
  logic [CHANNELS-1:0]   levels;
  logic [CHANNELS-1:0]   levels_next;
  logic [CHANNELS-1:0]   count_zero;
  cmd_t                  last_raw_command;
  cmd_t                  last_raw_command_next;
  cmd_t                  settled_command;
  cmd_t                  settled_command_next;
  cmd_t                  decoded;
  logic [SETTLE_W-1:0]   settle_counter;
  logic [SETTLE_W-1:0]   settle_counter_next;
  logic [1:0]            disc_codes [2];
  logic [1:0]            disc_first_next;
  logic [1:0]            disc_second_next;

  // handshake
  logic raw_accept;
  logic load;

  assign load       = s1_valid && (!result_valid || !result_stall);
  assign raw_stall  = s1_valid && !load;
  assign raw_accept = raw_valid && !raw_stall;

  // config writes, out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_reg[GRP_SENSOR]   <= SENSOR_THR_RST;
      thr_reg[GRP_COMMAND]  <= COMMAND_THR_RST;
      thr_reg[GRP_ENCODER]  <= ENCODER_THR_RST;
      thr_reg[GRP_DISC]     <= DISC_THR_RST;
      thr_reg[GRP_DETECTOR] <= DETECTOR_THR_RST;
      settle_ticks          <= SETTLE_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SENSOR_THR:   thr_reg[GRP_SENSOR]   <= cfg_data[THR_W-1:0];
        REG_COMMAND_THR:  thr_reg[GRP_COMMAND]  <= cfg_data[THR_W-1:0];
        REG_ENCODER_THR:  thr_reg[GRP_ENCODER]  <= cfg_data[THR_W-1:0];
        REG_DISC_THR:     thr_reg[GRP_DISC]     <= cfg_data[THR_W-1:0];
        REG_DETECTOR_THR: thr_reg[GRP_DETECTOR] <= cfg_data[THR_W-1:0];
        REG_SETTLE:       settle_ticks          <= cfg_data[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // per-channel integrating counters, each channel independent
  always_comb begin
    logic [CMP_W-1:0] thr_ext;
    logic [CMP_W-1:0] cnt_ext;
    thr_ext = '0;
    cnt_ext = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      thr_ext        = CMP_W'(thr_reg[group_of(i)]);
      cnt_ext        = CMP_W'(counts[i]);
      counts_next[i] = counts[i];
      if (!s1_raw[i] && counts[i] != '0) begin
        counts_next[i] = counts[i] - 1'b1;
      end else if (s1_raw[i] && cnt_ext < thr_ext && counts[i] != CNT_MAX) begin
        counts_next[i] = counts[i] + 1'b1;
      end
      // level holds between zero and the threshold
      levels_next[i] = levels[i];
      if (counts_next[i] == '0) begin
        levels_next[i] = 1'b0;
      end else if (CMP_W'(counts_next[i]) >= thr_ext) begin
        levels_next[i] = 1'b1;
      end
      count_zero[i] = (counts[i] == '0);
    end
  end

  // command settling: a changed code restarts the count and reads none
  always_comb begin
    logic [SETTLE_W-1:0] cnt_base;
    decoded               = decode_command(levels_next[CH_CMD_A], levels_next[CH_CMD_B]);
    cnt_base              = settle_counter;
    last_raw_command_next = last_raw_command;
    settled_command_next  = settled_command;
    if (decoded != last_raw_command) begin
      cnt_base              = '0;
      last_raw_command_next = decoded;
      settled_command_next  = CMD_NONE;
    end
    settle_counter_next = cnt_base;
    if (cnt_base < settle_ticks) begin
      settle_counter_next = cnt_base + 1'b1;
    end else begin
      settled_command_next = decoded;
    end
  end

  assign disc_first_next  = {levels_next[CH_DISC1_HI], levels_next[CH_DISC1_LO]};
  assign disc_second_next = {levels_next[CH_DISC2_HI], levels_next[CH_DISC2_LO]};

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (raw_accept) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_accept) begin
      s1_raw <= raw_pins;
    end
  end

  // state advances once per item, as its result is loaded
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        counts[i] <= '0;
      end
      levels           <= '0;
      last_raw_command <= CMD_NONE;
      settled_command  <= CMD_NONE;
      settle_counter   <= '0;
      disc_codes[0]    <= '0;
      disc_codes[1]    <= '0;
    end else if (load) begin
      for (int i = 0; i < CHANNELS; i++) begin
        counts[i] <= counts_next[i];
      end
      levels           <= levels_next;
      last_raw_command <= last_raw_command_next;
      settled_command  <= settled_command_next;
      settle_counter   <= settle_counter_next;
      disc_codes[0]    <= disc_first_next;
      disc_codes[1]    <= disc_second_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stable_pins         <= levels_next;
      command_code        <= settled_command_next;
      disc_code_first     <= disc_first_next;
      disc_code_second    <= disc_second_next;
      disc_changed_first  <= (disc_first_next != disc_codes[0]);
      disc_changed_second <= (disc_second_next != disc_codes[1]);
    end
  end

`ifndef NO_ASSERTIONS
  // a settled command other than none is always the code currently being tracked
  a_settled_tracks: assert property (@(posedge clk) disable iff (rst)
    settled_command != CMD_NONE |-> settled_command == last_raw_command)
    else $error("settled command differs from tracked code");

  // a channel whose count is zero reads low
  a_zero_low: assert property (@(posedge clk) disable iff (rst)
    (levels & count_zero) == '0)
    else $error("channel level high at count zero");

  // an item held in the input register is not dropped while stalled
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !load |=> s1_valid)
    else $error("stalled item lost from input register");

  // the input side only stalls with an item waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    raw_stall |-> s1_valid && result_valid && result_stall)
    else $error("input stalled without a full pipeline");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import mcid_pkg::*;

  // run limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 1000000;
  // indexes past the last register, writes there must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;
  localparam logic [COUNT_BITS_DEF-1:0] COUNT_FULL = '1;

  typedef struct packed {
    logic [CHANNELS-1:0] stable;
    cmd_t                command;
    logic [1:0]          disc_first;
    logic [1:0]          disc_second;
    logic                changed_first;
    logic                changed_second;
  } tick_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic raw_valid = 1'b0;
  logic raw_stall;
  logic [CHANNELS-1:0] raw_pins = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [CHANNELS-1:0] stable_pins;
  logic [1:0] command_code;
  logic [1:0] disc_code_first;
  logic [1:0] disc_code_second;
  logic disc_changed_first;
  logic disc_changed_second;

  multi_channel_integrating_debouncer DUT (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .raw_valid           (raw_valid),
    .raw_stall           (raw_stall),
    .raw_pins            (raw_pins),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .stable_pins         (stable_pins),
    .command_code        (command_code),
    .disc_code_first     (disc_code_first),
    .disc_code_second    (disc_code_second),
    .disc_changed_first  (disc_changed_first),
    .disc_changed_second (disc_changed_second)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // debouncer model: per-channel counters and levels, command settling, disc
  // codes, plus a shadow of the config registers
  // ---------------------------------------------------------------------------
  group_t chan_group [CHANNELS] = '{
    GRP_SENSOR, GRP_SENSOR, GRP_SENSOR, GRP_SENSOR,
    GRP_COMMAND, GRP_COMMAND,
    GRP_ENCODER, GRP_ENCODER, GRP_DISC, GRP_DISC,
    GRP_ENCODER, GRP_ENCODER, GRP_DISC, GRP_DISC,
    GRP_DETECTOR
  };

  logic [SETTLE_W-1:0]       cfg_shadow [6];
  logic [COUNT_BITS_DEF-1:0] chan_count [CHANNELS];
  logic [CHANNELS-1:0]       chan_level;
  cmd_t                      last_decoded;
  cmd_t                      settled_cmd;
  logic [SETTLE_W-1:0]       settle_count;
  logic [1:0]                disc_prev [2];

  // items waiting to be offered, and results owed by the block
  logic [CHANNELS-1:0] pending_pins [$];
  tick_result_t        pending_results [$];

  int error_count = 0;
  int items_offered = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_roll;
  tick_result_t front_result;

  function automatic void debouncer_reset();
    cfg_shadow[REG_SENSOR_THR]   = {1'b0, SENSOR_THR_RST};
    cfg_shadow[REG_COMMAND_THR]  = {1'b0, COMMAND_THR_RST};
    cfg_shadow[REG_ENCODER_THR]  = {1'b0, ENCODER_THR_RST};
    cfg_shadow[REG_DISC_THR]     = {1'b0, DISC_THR_RST};
    cfg_shadow[REG_DETECTOR_THR] = {1'b0, DETECTOR_THR_RST};
    cfg_shadow[REG_SETTLE]       = SETTLE_RST;
    for (int ch = 0; ch < CHANNELS; ch++) chan_count[ch] = '0;
    chan_level   = '0;
    last_decoded = CMD_NONE;
    settled_cmd  = CMD_NONE;
    settle_count = '0;
    disc_prev[0] = 2'd0;
    disc_prev[1] = 2'd0;
  endfunction

  // one sampling tick: advance the model and return the result it owes
  function automatic tick_result_t debounce_tick(input logic [CHANNELS-1:0] pins);
    tick_result_t r;
    logic [THR_W-1:0] thr;
    logic [COUNT_BITS_DEF-1:0] c;
    cmd_t decoded;
    logic [1:0] code_first;
    logic [1:0] code_second;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      thr = cfg_shadow[chan_group[ch]][THR_W-1:0];
      c = chan_count[ch];
      // count saturates at the threshold and at the counter range
      if (!pins[ch] && c != '0) c = c - 1'b1;
      else if (pins[ch] && c < thr && c != COUNT_FULL) c = c + 1'b1;
      // level holds between zero and the threshold
      if (c == '0) chan_level[ch] = 1'b0;
      else if (c >= thr) chan_level[ch] = 1'b1;
      chan_count[ch] = c;
    end
    case ({chan_level[CH_CMD_A], chan_level[CH_CMD_B]})
      2'b11:   decoded = CMD_NONE;
      2'b01:   decoded = CMD_OPEN_IN;
      2'b10:   decoded = CMD_OPEN_OUT;
      default: decoded = CMD_PICTOGRAM;
    endcase
    // a new code restarts settling and reads none until it has held
    if (decoded != last_decoded) begin
      settle_count = '0;
      last_decoded = decoded;
      settled_cmd  = CMD_NONE;
    end
    if (settle_count < cfg_shadow[REG_SETTLE]) settle_count = settle_count + 1'b1;
    else settled_cmd = decoded;
    code_first  = {chan_level[CH_DISC1_HI], chan_level[CH_DISC1_LO]};
    code_second = {chan_level[CH_DISC2_HI], chan_level[CH_DISC2_LO]};
    r.stable         = chan_level;
    r.command        = settled_cmd;
    r.disc_first     = code_first;
    r.disc_second    = code_second;
    r.changed_first  = (code_first != disc_prev[0]);
    r.changed_second = (code_second != disc_prev[1]);
    disc_prev[0] = code_first;
    disc_prev[1] = code_second;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued items, random gaps after each offer, with stretches
  // of back-to-back items
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((items_offered / 128) % 3 == 1) return 0;
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(15, 30);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
      gap_left = 0;
    end else begin
      // item taken at this edge: the model predicts its result now
      if (raw_valid && !raw_stall) begin
        pending_results.push_back(debounce_tick(raw_pins));
        items_accepted++;
      end
      // the payload only moves once the current item is gone
      if (!raw_valid || !raw_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          raw_valid <= 1'b0;
        end else if (pending_pins.size() > 0) begin
          raw_pins  <= pending_pins.pop_front();
          raw_valid <= 1'b1;
          items_offered++;
          gap_left = pick_gap();
        end else begin
          raw_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result item against the oldest prediction and drives
  // result_stall with random holds
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int expected, input int actual);
    if (expected != actual) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result item with nothing expected, actual stable_pins %0h",
                   $time, stable_pins);
          error_count++;
        end else begin
          front_result = pending_results.pop_front();
          check_field("stable_pins", front_result.stable, stable_pins);
          check_field("command_code", front_result.command, command_code);
          check_field("disc_code_first", front_result.disc_first, disc_code_first);
          check_field("disc_code_second", front_result.disc_second, disc_code_second);
          check_field("disc_changed_first", front_result.changed_first,
                      disc_changed_first);
          check_field("disc_changed_second", front_result.changed_second,
                      disc_changed_second);
        end
        results_checked++;
        // long hold while the sender keeps offering, fills the block
        if (results_checked == 150 || results_checked == 500) stall_left = 60;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else if ((results_checked / 128) % 3 == 2) begin
        // calm stretch, no holds
        result_stall <= 1'b0;
      end else begin
        stall_roll = $urandom_range(0, 99);
        if (stall_roll < 65) begin
          result_stall <= 1'b0;
        end else begin
          if (stall_roll < 90) stall_left = $urandom_range(0, 2);
          else if (stall_roll < 97) stall_left = $urandom_range(3, 8);
          else stall_left = $urandom_range(10, 30);
          result_stall <= 1'b1;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still owed", $time, pending_results.size());
      $display("multi_channel_integrating_debouncer test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // config writes only happen while nothing is in flight, so the shadow copy
  // can follow at once
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    if (idx == REG_SETTLE) cfg_shadow[idx] = data;
    else if (idx < REG_SETTLE) cfg_shadow[idx] = {1'b0, data[THR_W-1:0]};
    @(posedge clk);
    cfg_write <= 1'b0;
    cfg_writes++;
  endtask

  task automatic set_thresholds(input logic [CFG_DATA_W-1:0] sensor,
                                input logic [CFG_DATA_W-1:0] command,
                                input logic [CFG_DATA_W-1:0] encoder,
                                input logic [CFG_DATA_W-1:0] disc,
                                input logic [CFG_DATA_W-1:0] detector);
    write_reg(REG_SENSOR_THR, sensor);
    write_reg(REG_COMMAND_THR, command);
    write_reg(REG_ENCODER_THR, encoder);
    write_reg(REG_DISC_THR, disc);
    write_reg(REG_DETECTOR_THR, detector);
  endtask

  // wait until every item is taken and every result is back, then a margin
  task automatic drain();
    do @(negedge clk);
    while (pending_pins.size() != 0 || raw_valid || pending_results.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return 11'd1023;
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  // bouncing pins: each channel follows a slowly changing target level with
  // random bounce, plus some fully random ticks as noise
  task automatic queue_bouncy(input int n);
    logic [CHANNELS-1:0] target;
    logic [CHANNELS-1:0] pins;
    target = CHANNELS'($urandom);
    for (int k = 0; k < n; k++) begin
      for (int ch = 0; ch < CHANNELS; ch++)
        if ($urandom_range(0, 19) == 0) target[ch] = ~target[ch];
      if ($urandom_range(0, 9) == 0) begin
        pins = CHANNELS'($urandom);
      end else begin
        pins = target;
        for (int ch = 0; ch < CHANNELS; ch++)
          if ($urandom_range(0, 99) < 15) pins[ch] = ~pins[ch];
      end
      pending_pins.push_back(pins);
    end
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [CHANNELS-1:0] pins;
    debouncer_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset defaults: all low, all high, alternating patterns
    pending_pins.push_back(15'h0000);
    pending_pins.push_back(15'h7fff);
    pending_pins.push_back(15'h7fff);
    pending_pins.push_back(15'h7fff);
    pending_pins.push_back(15'h0000);
    pending_pins.push_back(15'h5555);
    pending_pins.push_back(15'h2aaa);
    drain();

    // unit thresholds, no settling: every command code and disc code changes on both pairs
    set_thresholds(11'd1, 11'd1, 11'd1, 11'd1, 11'd1);
    write_reg(REG_SETTLE, '0);
    // out-of-range indexes must leave every register alone
    write_reg(REG_UNUSED_6, CFG_DATA_W'($urandom));
    write_reg(REG_UNUSED_7, 11'h7ff);
    pending_pins.push_back(15'h0000);   // both command pins low: pictogram
    pending_pins.push_back(15'h0010);   // ch4 only: open out
    pending_pins.push_back(15'h0020);   // ch5 only: open in
    pending_pins.push_back(15'h0030);   // both high: none
    pending_pins.push_back(15'h0300);   // first disc code 3
    pending_pins.push_back(15'h0100);
    pending_pins.push_back(15'h3000);   // second disc code 3
    pending_pins.push_back(15'h2000);
    pending_pins.push_back(15'h4000);   // detector alone
    pending_pins.push_back(15'h7fff);
    pending_pins.push_back(15'h0000);
    drain();

    // count up to 2, then drop thresholds under the count and to zero;
    // bit 10 of the sensor write falls outside the register
    set_thresholds(11'h403, 11'd3, 11'd3, 11'd3, 11'd3);
    pending_pins.push_back(15'h7fff);
    pending_pins.push_back(15'h7fff);
    drain();
    set_thresholds(11'd0, 11'd0, 11'd0, 11'd1, 11'd1);
    pending_pins.push_back(15'h7fff);
    pending_pins.push_back(15'h0000);
    pending_pins.push_back(15'h0000);
    pending_pins.push_back(15'h7fff);
    pending_pins.push_back(15'h0000);
    drain();

    // longest settle count, then lowered under the running counter
    set_thresholds(11'd1, 11'd1, 11'd1, 11'd1, 11'd1);
    write_reg(REG_SETTLE, 11'd2047);
    for (int k = 0; k < 20; k++) begin
      pins = CHANNELS'($urandom);
      pins[CH_CMD_A] = 1'b1;
      pins[CH_CMD_B] = 1'b0;
      pending_pins.push_back(pins);
    end
    drain();
    write_reg(REG_SETTLE, 11'd5);
    for (int k = 0; k < 4; k++) begin
      pins = CHANNELS'($urandom);
      pins[CH_CMD_A] = 1'b1;
      pins[CH_CMD_B] = 1'b0;
      pending_pins.push_back(pins);
    end
    drain();

    // large thresholds: counts climb far, only the detector reaches its level
    set_thresholds(11'h7ff, 11'd1023, 11'd1023, 11'd1023, 11'd150);
    write_reg(REG_SETTLE, 11'd2047);
    for (int k = 0; k < 200; k++) begin
      pins = 15'h7fff;
      if ($urandom_range(0, 63) == 0) pins[$urandom_range(0, CHANNELS - 1)] = 1'b0;
      pending_pins.push_back(pins);
    end
    drain();

    // random settings with bouncing pins
    for (int p = 0; p < 6; p++) begin
      set_thresholds(pick_threshold(), pick_threshold(), pick_threshold(),
                     pick_threshold(), pick_threshold());
      write_reg(REG_SETTLE, (p == 0) ? 11'd0 : 11'($urandom_range(0, 12)));
      queue_bouncy(75);
      drain();
    end

    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      error_count++;
    end
    $display("covered %0d items and %0d result items over %0d register writes",
             items_accepted, results_checked, cfg_writes);
    $display("settings ran from zero and unit to full-scale thresholds, settle 0 to 2047");
    if (error_count == 0) begin
      $display("multi_channel_integrating_debouncer test passed");
    end else begin
      $display("multi_channel_integrating_debouncer test failed");
    end
    $finish;
  end

endmodule
